// ----- hw/rtl/itoa_pkg.sv -----
// Shared constants and helpers for the integer to ASCII digits block.
// Used by itoa_div and integer_to_ascii_digits; depends on nothing.
package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] LARGEST_DECIMAL_DIGIT = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  localparam logic REG_RADIX = 1'b0;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > LARGEST_DECIMAL_DIGIT) begin
      c = CHAR_LOWER_A + CHAR_W'(d - RADIX_DECIMAL);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/itoa_div.sv -----
// Bit-serial restoring divider of a word by a radix of up to 36.
// Depends on itoa_pkg for the radix width.
module itoa_div #(
  parameter int W = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [W-1:0]                 dividend,
  input  logic [itoa_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [W-1:0]                 quotient,
  output logic [itoa_pkg::RADIX_W-1:0] remainder
);

  localparam int SW = (W > 1) ? $clog2(W) : 1;

  logic                         busy;
  logic [SW-1:0]                step;
  logic [W-1:0]                 work;
  logic [itoa_pkg::RADIX_W-1:0] rem;

  logic [itoa_pkg::RADIX_W:0]   trial;
  logic [itoa_pkg::RADIX_W:0]   trial_sub;
  logic                         fits;
  logic [itoa_pkg::RADIX_W-1:0] rem_next;

  always_comb begin
    trial = {rem, work[W-1]};
    fits = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
    rem_next = fits ? trial_sub[itoa_pkg::RADIX_W-1:0] : trial[itoa_pkg::RADIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= SW'(W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem <= '0;
    end else if (busy) begin
      work <= {work[W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = work;
  assign remainder = rem;

endmodule

// ----- hw/rtl/integer_to_ascii_digits.sv -----
// Top level of the integer to ASCII digits converter.
// Depends on itoa_pkg and the serial divider itoa_div.
//
// One word at a time is converted. After a word is taken, a non-zero value
// is divided digit by digit in the shared serial divider, one bit of the
// quotient per cycle, while zero needs no division at all. A finishing
// state closes the conversion; a leading minus and then each digit, read
// and loaded from the digit store, are each held until the output takes it.
// Input is stalled from the moment a word is taken until its last character
// has been delivered. The radix register at byte address 0 reads back the
// six bits written; values below 2 convert as base 2, above 36 as base 36.
module integer_to_ascii_digits #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]   character,
  output logic                          last
);

  localparam int IW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CW = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DSTART = 3'd1;
  localparam logic [2:0] ST_DWAIT  = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_LOAD   = 3'd5;
  localparam logic [2:0] ST_OWAIT  = 3'd6;

  logic [2:0]                   state;
  logic [itoa_pkg::RADIX_W-1:0] radix;
  logic [itoa_pkg::RADIX_W-1:0] eff_radix;
  logic [CW-1:0]                digit_count;
  logic                         is_negative;
  logic [VALUE_BITS-1:0]        remaining_magnitude;

  logic [itoa_pkg::RADIX_W-1:0] digit_store [VALUE_BITS];
  logic [itoa_pkg::RADIX_W-1:0] rd_data;

  logic                         cfg_write;
  logic                         in_accept;
  logic                         out_accept;
  logic [VALUE_BITS-1:0]        word;
  logic [itoa_pkg::RADIX_W-1:0] start_radix;
  logic                         start_negative;
  logic [VALUE_BITS-1:0]        start_magnitude;
  logic [CW-1:0]                count_m1;
  logic [CW-1:0]                count_p1;

  logic                         div_start;
  logic                         div_done;
  logic [VALUE_BITS-1:0]        div_quotient;
  logic [itoa_pkg::RADIX_W-1:0] div_rem;

  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  logic [itoa_pkg::RADIX_W-1:0] mem_wdata;

  assign pready = 1'b1;
  assign prdata = {{(32 - itoa_pkg::RADIX_W){1'b0}}, radix};
  assign cfg_write = psel && penable && pwrite && (paddr[2] == itoa_pkg::REG_RADIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::RADIX_RESET;
    end else if (cfg_write) begin
      radix <= pwdata[itoa_pkg::RADIX_W-1:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  always_comb begin
    word = value;
    start_radix = itoa_pkg::clamp_radix(radix);
    start_negative = (start_radix == itoa_pkg::RADIX_DECIMAL) && word[VALUE_BITS-1];
    start_magnitude = start_negative ? (~word + 1'b1) : word;
    count_m1 = digit_count - 1'b1;
    count_p1 = digit_count + 1'b1;
  end

  assign div_start = (state == ST_DSTART);

  itoa_div #(
    .W(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining_magnitude),
    .divisor  (eff_radix),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_rem)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = digit_count[IW-1:0];
    mem_wdata = div_rem;
    if (in_accept && (start_magnitude == '0)) begin
      mem_we = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if ((state == ST_DWAIT) && div_done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= digit_store[count_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      digit_count <= '0;
      is_negative <= 1'b0;
      remaining_magnitude <= '0;
      eff_radix <= itoa_pkg::RADIX_DECIMAL;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            eff_radix <= start_radix;
            is_negative <= start_negative;
            remaining_magnitude <= start_magnitude;
            if (start_magnitude == '0) begin
              digit_count <= CW'(1);
              state <= ST_FIN;
            end else begin
              digit_count <= '0;
              state <= ST_DSTART;
            end
          end
        end
        ST_DSTART: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            digit_count <= count_p1;
            remaining_magnitude <= div_quotient;
            if ((div_quotient == '0) || (count_p1 == CW'(VALUE_BITS))) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DSTART;
            end
          end
        end
        ST_FIN: begin
          if (is_negative) begin
            out_valid <= 1'b1;
            state <= ST_OWAIT;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          digit_count <= count_m1;
          out_valid <= 1'b1;
          state <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (out_accept) begin
            out_valid <= 1'b0;
            state <= last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && is_negative) begin
      character <= itoa_pkg::CHAR_MINUS;
      last <= 1'b0;
    end else if (state == ST_LOAD) begin
      character <= itoa_pkg::digit_char(rd_data);
      last <= (digit_count == CW'(1));
    end
  end

  a_out_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OWAIT))
    else $error("result word shown outside the output wait state");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !out_valid && (digit_count <= CW'(VALUE_BITS)))
    else $error("input word taken while a result is pending");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DWAIT))
    else $error("divider finished outside the division wait state");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(VALUE_BITS))
    else $error("digit count exceeds the word width");

  a_load_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (digit_count != '0))
    else $error("character loaded with no digit left");

endmodule
